@@ sv/svh_pkg.sv @@
package svh_pkg;

   localparam int KEY_BITS   = 32;
   localparam int COUNT_OUT_BITS = 16;

   // command codes on the request channel
   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_REPORT = 1'b1;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_ADD,
      CELL_POP
   } cell_op_type;

   // status a cell hands to its right neighbor
   typedef struct packed {
      logic valid;
      logic lt;
   } cell_tag_type;

   typedef enum logic {
      ST_IDLE,
      ST_REPORT
   } state_type;

endpackage

@@ sv/svh_if.sv @@
interface svh_req_if;
   logic                valid;
   logic                ready;
   logic                command;
   logic signed [31:0]  value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

interface svh_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  key;
   logic [15:0]         count;
   logic                last_pair;
   logic                overflowed;

   modport source (output valid, output key, output count, output last_pair,
                   output overflowed, input ready);
   modport sink   (input valid, input key, input count, input last_pair,
                   input overflowed, output ready);
endinterface

@@ sv/svh_cell.sv @@
module svh_cell #(
   parameter int COUNT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  svh_pkg::cell_op_type          op,
   input  logic                          hit,
   input  logic                          full,
   input  logic signed [31:0]            value,
   input  svh_pkg::cell_tag_type         left_tag,
   input  logic signed [31:0]            left_key,
   input  logic [COUNT_BITS-1:0]         left_count,
   input  logic                          right_valid,
   input  logic signed [31:0]            right_key,
   input  logic [COUNT_BITS-1:0]         right_count,
   output svh_pkg::cell_tag_type         tag,
   output logic                          eq,
   output logic signed [31:0]            key,
   output logic [COUNT_BITS-1:0]         count
);
   import svh_pkg::*;

   logic                   valid_ff, valid_in;
   logic signed [31:0]     key_ff, key_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   lt;

   assign lt        = valid_ff && (key_ff < value);
   assign eq        = valid_ff && (key_ff == value);
   assign tag.valid = valid_ff;
   assign tag.lt    = lt;
   assign key       = key_ff;
   assign count     = count_ff;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      count_in = count_ff;
      unique case (op)
         CELL_HOLD: begin
         end
         CELL_ADD: begin
            if (hit) begin
               if (eq && (count_ff != {COUNT_BITS{1'b1}})) begin
                  count_in = count_ff + COUNT_BITS'(1);
               end
            end else if (!full && !lt) begin
               // left neighbor smaller: this is the insertion slot
               if (left_tag.lt) begin
                  valid_in = 1'b1;
                  key_in   = value;
                  count_in = COUNT_BITS'(1);
               end else begin
                  valid_in = left_tag.valid;
                  key_in   = left_key;
                  count_in = left_count;
               end
            end
         end
         CELL_POP: begin
            valid_in = right_valid;
            key_in   = right_key;
            count_in = right_count;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      count_ff <= count_in;
   end

endmodule

@@ sv/sorted_value_histogram.sv @@
// Add: compared against every cell at once; ready again the next cycle.
// Report: the state register moves to report, then the head pair is loaded into the output
//   register, then one pair per cycle while the sink takes them, until the row is empty.
// The row of MAX_KEYS cells shifts right on insert and left on report, one step a cycle while it moves.
// Reset (synchronous): clears all cell valid bits, the overflow flag, state and rsp valid.
module sorted_value_histogram #(
   parameter int MAX_KEYS   = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   svh_req_if.sink       req_if,
   svh_rsp_if.source     rsp_if
);
   import svh_pkg::*;

   state_type                state_ff, state_in;
   cell_op_type              op;
   logic                     req_ready;
   logic                     pop;
   logic                     hit;
   logic                     full;
   logic [MAX_KEYS-1:0]      valid_vec;
   logic [MAX_KEYS-1:0]      eq_vec;
   logic                     overflow_ff, overflow_in;

   cell_tag_type             tag_w   [MAX_KEYS];
   logic signed [31:0]       key_w   [MAX_KEYS];
   logic [COUNT_BITS-1:0]    count_w [MAX_KEYS];

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]       rsp_key_ff;
   logic [15:0]              rsp_count_ff;
   logic                     rsp_last_ff;
   logic                     rsp_ovf_ff;

   assign hit  = |eq_vec;
   assign full = valid_vec[MAX_KEYS-1];

   for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
      cell_tag_type           l_tag;
      logic signed [31:0]     l_key;
      logic [COUNT_BITS-1:0]  l_count;
      logic                   r_valid;
      logic signed [31:0]     r_key;
      logic [COUNT_BITS-1:0]  r_count;

      if (i == 0) begin : g_first
         assign l_tag   = '{valid: 1'b0, lt: 1'b1};
         assign l_key   = key_w[i];
         assign l_count = count_w[i];
      end else begin : g_mid
         assign l_tag   = tag_w[i-1];
         assign l_key   = key_w[i-1];
         assign l_count = count_w[i-1];
      end

      if (i == MAX_KEYS-1) begin : g_last
         assign r_valid = 1'b0;
         assign r_key   = key_w[i];
         assign r_count = count_w[i];
      end else begin : g_inner
         assign r_valid = tag_w[i+1].valid;
         assign r_key   = key_w[i+1];
         assign r_count = count_w[i+1];
      end

      svh_cell #(
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (op),
         .hit         (hit),
         .full        (full),
         .value       (req_if.value),
         .left_tag    (l_tag),
         .left_key    (l_key),
         .left_count  (l_count),
         .right_valid (r_valid),
         .right_key   (r_key),
         .right_count (r_count),
         .tag         (tag_w[i]),
         .eq          (eq_vec[i]),
         .key         (key_w[i]),
         .count       (count_w[i])
      );

      assign valid_vec[i] = tag_w[i].valid;
   end

   always_comb begin
      state_in  = state_ff;
      op        = CELL_HOLD;
      req_ready = 1'b0;
      pop       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_if.valid) begin
               if (req_if.command == CMD_REPORT) begin
                  state_in = ST_REPORT;
               end else begin
                  op = CELL_ADD;
               end
            end
         end
         ST_REPORT: begin
            if (!valid_vec[0]) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_if.ready) begin
               pop = 1'b1;
               op  = CELL_POP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      overflow_in = overflow_ff;
      if (state_ff == ST_REPORT && !valid_vec[0]) begin
         overflow_in = 1'b0;
      end else if (op == CELL_ADD && !hit && full) begin
         overflow_in = 1'b1;
      end
   end

   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load the head cell into the output register as it leaves the row
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_key_ff   <= key_w[0];
         rsp_count_ff <= 16'(count_w[0]);
         rsp_last_ff  <= !valid_vec[1];
         rsp_ovf_ff   <= overflow_ff;
      end
   end

   assign req_if.ready      = req_ready;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.key        = rsp_key_ff;
   assign rsp_if.count      = rsp_count_ff;
   assign rsp_if.last_pair  = rsp_last_ff;
   assign rsp_if.overflowed = rsp_ovf_ff;

   // occupied cells always form a prefix of the row
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + MAX_KEYS'(1)) & valid_vec) == '0)
      else $error("histogram cells are not a contiguous prefix");

   a_overflow_on_full: assert property (@(posedge clock) disable iff (reset)
      $rose(overflow_ff) |-> $past(full) && !$past(hit))
      else $error("overflow set while a cell was free or key present");

   a_report_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPORT && !valid_vec[0]) |=> (valid_vec == '0) && !overflow_ff)
      else $error("table or overflow not cleared after report");

   a_report_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && req_if.command == CMD_REPORT) |=> !req_if.ready)
      else $error("request taken during a report");

endmodule

@@ bench/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import svh_pkg::*;

   localparam int TB_MAX_KEYS   = 32;
   localparam int TB_COUNT_BITS = 16;
   localparam logic [COUNT_OUT_BITS-1:0] COUNT_CAP = 16'hFFFF;
   localparam int N_ROWS = 24;
   // typed expectation kinds for directed rows
   localparam int FROM_MODEL = -1;
   localparam int NO_PAIRS   = 0;
   localparam int ONE_PAIR   = 1;

   typedef struct {
      logic signed [KEY_BITS-1:0]   key;
      logic [COUNT_OUT_BITS-1:0]    count;
      logic                         last_pair;
      logic                         overflowed;
   } hist_pair_type;

   typedef struct {
      logic                         cmd;
      logic signed [KEY_BITS-1:0]   value;
      int                           reps;
      int                           stride;
      int                           n_typed;
      logic signed [KEY_BITS-1:0]   exp_key;
      logic [COUNT_OUT_BITS-1:0]    exp_count;
      logic                         exp_last;
      logic                         exp_ovf;
   } stim_row_type;

   logic clock;
   logic reset;
   bit   quiet;
   int   gap_odds;
   int   mismatches;

   hist_pair_type pending_pairs[$];

   logic signed [KEY_BITS-1:0]   hist_keys   [TB_MAX_KEYS];
   logic [COUNT_OUT_BITS-1:0]    hist_counts [TB_MAX_KEYS];
   int                           hist_used;
   logic                         hist_ovf;

   stim_row_type directed_rows [N_ROWS] = '{
      '{CMD_REPORT, 32'sh0000_0000, 1, 0, NO_PAIRS, 0, 0, 0, 0},
      '{CMD_ADD, 32'sh7FFF_FFFF, 1, 0, FROM_MODEL, 0, 0, 0, 0},
      '{CMD_REPORT, 32'sh0000_0000, 1, 0, ONE_PAIR, 32'sh7FFF_FFFF, 16'd1, 1'b1, 1'b0},
      '{CMD_ADD, 32'sh8000_0000, 3, 0, FROM_MODEL, 0, 0, 0, 0},
      '{CMD_REPORT, 32'shFFFF_FFFF, 1, 0, ONE_PAIR, 32'sh8000_0000, 16'd3, 1'b1, 1'b0},
      '{CMD_ADD, 32'sh0000_0000, 1, 0, FROM_MODEL, 0, 0, 0, 0},
      '{CMD_ADD, 32'shFFFF_FFFF, 1, 0, FROM_MODEL, 0, 0, 0, 0},
      '{CMD_ADD, 32'sh0000_0001, 1, 0, FROM_MODEL, 0, 0, 0, 0},
      '{CMD_ADD, 32'sh8000_0000, 1, 0, FROM_MODEL, 0, 0, 0, 0},
      '{CMD_ADD, 32'sh7FFF_FFFF, 2, 0, FROM_MODEL, 0, 0, 0, 0},
      '{CMD_ADD, 32'sh0000_0000, 1, 0, FROM_MODEL, 0, 0, 0, 0},
      '{CMD_REPORT, 32'sh5555_AAAA, 1, 0, FROM_MODEL, 0, 0, 0, 0},
      '{CMD_REPORT, 32'sh0000_0000, 1, 0, NO_PAIRS, 0, 0, 0, 0},
      '{CMD_ADD, 32'sh0000_0005, 20, 0, FROM_MODEL, 0, 0, 0, 0},
      '{CMD_REPORT, 32'sh0000_0000, 1, 0, ONE_PAIR, 32'sh0000_0005, 16'd20, 1'b1, 1'b0},
      '{CMD_ADD, -32'sd16, TB_MAX_KEYS, 1, FROM_MODEL, 0, 0, 0, 0},
      '{CMD_ADD, 32'sd100, 1, 0, FROM_MODEL, 0, 0, 0, 0},
      '{CMD_ADD, -32'sd16, 1, 0, FROM_MODEL, 0, 0, 0, 0},
      '{CMD_REPORT, 32'sh0000_0000, 1, 0, FROM_MODEL, 0, 0, 0, 0},
      '{CMD_ADD, 32'sd7, 1, 0, FROM_MODEL, 0, 0, 0, 0},
      '{CMD_REPORT, 32'sh0000_0000, 1, 0, ONE_PAIR, 32'sd7, 16'd1, 1'b1, 1'b0},
      '{CMD_ADD, 32'sd1000, TB_MAX_KEYS + 1, -3, FROM_MODEL, 0, 0, 0, 0},
      '{CMD_ADD, 32'sh8000_0000, 1, 0, FROM_MODEL, 0, 0, 0, 0},
      '{CMD_REPORT, 32'sh0000_0000, 1, 0, FROM_MODEL, 0, 0, 0, 0}
   };

   svh_req_if req_ch ();
   svh_rsp_if rsp_ch ();

   sorted_value_histogram #(
      .MAX_KEYS   (TB_MAX_KEYS),
      .COUNT_BITS (TB_COUNT_BITS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("sorted_value_histogram regression: fail");
      $finish;
   end

   function automatic void tally_value(logic signed [KEY_BITS-1:0] v);
      int pos;
      int i;
      pos = 0;
      while (pos < hist_used && hist_keys[pos] < v)
         pos++;
      if (pos < hist_used && hist_keys[pos] == v) begin
         if (hist_counts[pos] != COUNT_CAP)
            hist_counts[pos]++;
         return;
      end
      if (hist_used >= TB_MAX_KEYS) begin
         hist_ovf = 1'b1;
         return;
      end
      for (i = hist_used; i > pos; i--) begin
         hist_keys[i]   = hist_keys[i-1];
         hist_counts[i] = hist_counts[i-1];
      end
      hist_keys[pos]   = v;
      hist_counts[pos] = COUNT_OUT_BITS'(1);
      hist_used++;
   endfunction

   // Emit the sorted pairs (when keep is set), then clear the table and the flag.
   function automatic void drain_table(bit keep);
      hist_pair_type p;
      int i;
      for (i = 0; i < hist_used; i++) begin
         p.key        = hist_keys[i];
         p.count      = hist_counts[i];
         p.last_pair  = (i + 1 == hist_used);
         p.overflowed = hist_ovf;
         if (keep)
            pending_pairs = {pending_pairs, p};
      end
      hist_used = 0;
      hist_ovf  = 1'b0;
   endfunction

   task automatic log_mismatch(string what, hist_pair_type want, hist_pair_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s: expected key %0d count %0d last %0b ovf %0b",
                  $realtime, what, want.key, want.count, want.last_pair, want.overflowed);
         $display("%0t: %s: got key %0d count %0d last %0b ovf %0b",
                  $realtime, what, got.key, got.count, got.last_pair, got.overflowed);
      end
   endtask

   task automatic apply_request(logic cmd, logic signed [KEY_BITS-1:0] val, bit keep);
      int gap;
      if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
         gap = $urandom_range(1, 17);
         repeat (gap) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.value   <= val;
      do
         @(posedge clock);
      while (!req_ch.ready);
      if (cmd == CMD_ADD)
         tally_value(val);
      else
         drain_table(keep);
   endtask

   // Response side: random stall bursts, with calm stretches, none once quiet.
   initial begin
      int stall;
      int calm;
      stall = 0;
      calm  = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (calm > 0)
            calm--;
         else if (stall == 0 && $urandom_range(0, 59) == 0)
            calm = $urandom_range(20, 80);
         if (!quiet && calm == 0 && stall == 0 && $urandom_range(0, 5) == 0)
            stall = $urandom_range(1, 17);
         if (stall > 0 && !quiet) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall = 0;
         end
      end
   end

   always @(posedge clock) begin
      hist_pair_type want;
      hist_pair_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.key        = rsp_ch.key;
         got.count      = rsp_ch.count;
         got.last_pair  = rsp_ch.last_pair;
         got.overflowed = rsp_ch.overflowed;
         if (pending_pairs.size() == 0) begin
            want = '{default: 'x};
            log_mismatch("unexpected pair", want, got);
         end else begin
            want = pending_pairs.pop_front();
            if (got.key !== want.key || got.count !== want.count ||
                got.last_pair !== want.last_pair || got.overflowed !== want.overflowed)
               log_mismatch("pair mismatch", want, got);
         end
      end
   end

   initial begin
      int r;
      int k;
      int n;
      int mode;
      int sent;
      bit first;
      logic signed [KEY_BITS-1:0] pool [6];
      logic signed [KEY_BITS-1:0] v;
      hist_pair_type typed;

      reset          = 1'b1;
      quiet          = 1'b0;
      gap_odds       = 4;
      mismatches     = 0;
      hist_used      = 0;
      hist_ovf       = 1'b0;
      req_ch.valid   = 1'b0;
      req_ch.command = CMD_ADD;
      req_ch.value   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (r = 0; r < N_ROWS; r++) begin
         // run long repeat rows back to back
         gap_odds = (directed_rows[r].reps > 2 * TB_MAX_KEYS) ? 0 : 4;
         for (k = 0; k < directed_rows[r].reps; k++)
            apply_request(directed_rows[r].cmd,
                          directed_rows[r].value + k * directed_rows[r].stride,
                          directed_rows[r].n_typed == FROM_MODEL);
         if (directed_rows[r].n_typed == ONE_PAIR) begin
            typed.key        = directed_rows[r].exp_key;
            typed.count      = directed_rows[r].exp_count;
            typed.last_pair  = directed_rows[r].exp_last;
            typed.overflowed = directed_rows[r].exp_ovf;
            pending_pairs = {pending_pairs, typed};
         end
      end

      sent  = 0;
      first = 1'b1;
      while (sent < 200) begin
         quiet = (sent >= 160);
         case ($urandom_range(0, 2))
            0: gap_odds = 0;
            1: gap_odds = 3;
            default: gap_odds = 8;
         endcase
         if (quiet)
            gap_odds = 0;
         foreach (pool[i])
            pool[i] = $urandom;
         mode = $urandom_range(0, 4);
         case (mode)
            0: n = $urandom_range(1, 20);
            1: n = $urandom_range(1, 25);
            2: n = $urandom_range(30, 40);
            3: n = $urandom_range(1, 12);
            default: n = 0;
         endcase
         for (k = 0; k < n; k++) begin
            case (mode)
               0: begin
                  v = $urandom_range(0, 8);
                  v = v - 4;
               end
               1: v = pool[$urandom_range(0, 5)];
               3: v = $urandom_range(0, 1) ? 32'sh8000_0000 + $urandom_range(0, 3)
                                           : 32'sh7FFF_FFFF - $urandom_range(0, 3);
               default: v = $urandom;
            endcase
            apply_request(CMD_ADD, v, 1'b1);
            sent++;
         end
         apply_request(CMD_REPORT, $urandom, 1'b1);
         sent++;
         if ($urandom_range(0, 7) == 0) begin
            apply_request(CMD_REPORT, $urandom, 1'b1);
            sent++;
         end
         if (first || (!quiet && $urandom_range(0, 5) == 0)) begin
            // hold the request side until every pair is out
            @(negedge clock);
            req_ch.valid <= 1'b0;
            while (pending_pairs.size() != 0)
               @(posedge clock);
            first = 1'b0;
         end
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_pairs.size() != 0)
         @(posedge clock);
      repeat (2 * TB_MAX_KEYS + 8) @(posedge clock);
      if (mismatches == 0 && pending_pairs.size() == 0)
         $display("sorted_value_histogram regression: pass");
      else
         $display("sorted_value_histogram regression: fail");
      $finish;
   end

endmodule
